FILE: rtl/core/ed3_pkg.sv
// Shared types, constants and arithmetic helpers of the 3x3 edge detector.
package ed3_pkg;

   localparam int PIX_W    = 8;
   localparam int CSR_W    = 13;
   localparam int CSR_IDX_W = 2;
   localparam int ROW_W    = 13;
   localparam int SUM_W    = 12;
   localparam int SQ_W     = 17;
   localparam int ROOT_W   = 18;
   localparam int ROOT_STEPS = 9;
   localparam int STEP_W   = 4;
   localparam int MAX_HEIGHT = 4096;

   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd2;

   localparam logic [1:0] MODE_PREWITT = 2'd0;
   localparam logic [1:0] MODE_SOBEL   = 2'd1;

   typedef struct packed {
      logic capture;
      logic read;
      logic shift;
      logic calc;
      logic square;
      logic root_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic root_last;
      logic out_busy;
   } status_type;

   // Absolute value of a kernel sum, clamped to the pixel range.
   function automatic logic [PIX_W-1:0] abs_clamp(input logic signed [SUM_W-1:0] s);
      logic [SUM_W-1:0] a;
      a = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
      return (a > SUM_W'(255)) ? 8'hFF : a[PIX_W-1:0];
   endfunction

endpackage

FILE: rtl/core/ed3_req_if.sv
// Input channel: one pixel word with its padding flag.
interface ed3_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel;
   logic       is_padding;

   modport source (output valid, output pixel, output is_padding, input ready);
   modport sink   (input valid, input pixel, input is_padding, output ready);
endinterface

FILE: rtl/core/ed3_rsp_if.sv
// Result channel: one edge strength word with its frame end flag.
interface ed3_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] edge_value;
   logic       frame_end;

   modport source (output valid, output edge_value, output frame_end, input ready);
   modport sink   (input valid, input edge_value, input frame_end, output ready);
endinterface

FILE: rtl/core/ed3_ctrl.sv
// Sequencer that steps one pixel word through the edge detector datapath.
module ed3_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ed3_pkg::status_type status,
   output ed3_pkg::cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_READ  = 7'b0000010,
      ST_WIN   = 7'b0000100,
      ST_CALC  = 7'b0001000,
      ST_SQ    = 7'b0010000,
      ST_ROOT  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_WIN;
         end
         ST_WIN: begin
            cmd.shift = 1'b1;
            state_in  = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            cmd.square = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (status.root_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

FILE: rtl/core/ed3_datapath.sv
// Line stores, window, position counters, kernel sums, square root and result register.
module ed3_datapath #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [12:0]          csr_wdata,
   input  logic [7:0]           in_pixel,
   input  logic                 in_is_padding,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [7:0]           rsp_edge_value,
   output logic                 rsp_frame_end,
   input  ed3_pkg::cmd_type     cmd,
   output ed3_pkg::status_type  status
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = AW + 1;
   localparam int RW = ed3_pkg::ROW_W;
   localparam int PW = ed3_pkg::PIX_W;

   // Configuration registers.
   logic [1:0]  mode_ff;
   logic [12:0] fw_ff, fh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ed3_pkg::MODE_SOBEL;
         fw_ff   <= 13'd512;
         fh_ff   <= 13'd512;
      end else if (csr_we) begin
         unique case (csr_index)
            ed3_pkg::CSR_KERNEL_MODE:  mode_ff <= csr_wdata[1:0];
            ed3_pkg::CSR_FRAME_WIDTH:  fw_ff   <= csr_wdata;
            ed3_pkg::CSR_FRAME_HEIGHT: fh_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective frame size, saturated into the supported range.
   logic [CW-1:0] ew;
   logic [RW-1:0] eh;
   always_comb begin
      if (fw_ff < 13'd3) begin
         ew = CW'(3);
      end else if (32'(fw_ff) > 32'(MAX_WIDTH)) begin
         ew = CW'(MAX_WIDTH);
      end else begin
         ew = CW'(fw_ff);
      end
      if (fh_ff < 13'd3) begin
         eh = RW'(3);
      end else if (32'(fh_ff) > 32'(ed3_pkg::MAX_HEIGHT)) begin
         eh = RW'(ed3_pkg::MAX_HEIGHT);
      end else begin
         eh = RW'(fh_ff);
      end
   end

   // Position counters and the captured word.
   logic [AW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [AW-1:0] c_ff;
   logic [RW-1:0] r_ff;
   logic [PW-1:0] v_ff;
   logic [CW-1:0] c_next;

   assign c_next = CW'(c_ff) + CW'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.shift) begin
         if (r_ff >= eh + RW'(1)) begin
            col_in = '0;
            row_in = '0;
         end else if (c_next >= ew) begin
            col_in = '0;
            row_in = r_ff + RW'(1);
         end else begin
            col_in = c_next[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // A column left past a shrunken width wraps to the next row first.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         if (CW'(col_ff) >= ew) begin
            c_ff <= '0;
            r_ff <= row_ff + RW'(1);
         end else begin
            c_ff <= col_ff;
            r_ff <= row_ff;
         end
         v_ff <= in_is_padding ? '0 : in_pixel;
      end
   end

   // Line stores.
   logic [PW-1:0] store_a [MAX_WIDTH];
   logic [PW-1:0] store_b [MAX_WIDTH];
   logic [PW-1:0] rd_a_ff, rd_b_ff;

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_a_ff <= store_a[c_ff];
      end
      if (cmd.shift) begin
         store_a[c_ff] <= v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_b_ff <= store_b[c_ff];
      end
      if (cmd.shift) begin
         store_b[c_ff] <= rd_a_ff;
      end
   end

   // Window and border flags.
   logic [PW-1:0] win_ff [9];
   logic          has_ff, last_ff, inner_ff;
   logic [CW-1:0] pc;
   logic [RW-1:0] pr;

   always_comb begin
      if (c_ff != '0) begin
         pc = CW'(c_ff) - CW'(1);
         pr = r_ff - RW'(1);
      end else begin
         pc = ew - CW'(1);
         pr = r_ff - RW'(2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (cmd.shift) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i*3]   <= win_ff[i*3+1];
            win_ff[i*3+1] <= win_ff[i*3+2];
         end
         win_ff[2] <= rd_b_ff;
         win_ff[5] <= rd_a_ff;
         win_ff[8] <= v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         has_ff   <= !((r_ff == '0) || ((r_ff == RW'(1)) && (c_ff == '0)));
         last_ff  <= (r_ff >= eh + RW'(1));
         inner_ff <= (pr >= RW'(1)) && (pr <= eh - RW'(2)) &&
                     (pc >= CW'(1)) && (pc <= ew - CW'(2));
      end
   end

   // Kernel sums.
   localparam int SW = ed3_pkg::SUM_W;
   logic signed [SW-1:0] w [9];
   logic signed [SW-1:0] px, py, sx, sy, lp;
   logic [PW-1:0] gx_ff, gy_ff, lap_ff;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         w[i] = SW'(win_ff[i]);
      end
      px = (w[2] + w[5] + w[8]) - (w[0] + w[3] + w[6]);
      py = (w[6] + w[7] + w[8]) - (w[0] + w[1] + w[2]);
      sx = (w[2] + (w[5] <<< 1) + w[8]) - (w[0] + (w[3] <<< 1) + w[6]);
      sy = (w[6] + (w[7] <<< 1) + w[8]) - (w[0] + (w[1] <<< 1) + w[2]);
      lp = (w[1] + w[3] + w[5] + w[7]) - (w[4] <<< 2);
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         if (mode_ff == ed3_pkg::MODE_PREWITT) begin
            gx_ff <= ed3_pkg::abs_clamp(px);
            gy_ff <= ed3_pkg::abs_clamp(py);
         end else begin
            gx_ff <= ed3_pkg::abs_clamp(sx);
            gy_ff <= ed3_pkg::abs_clamp(sy);
         end
         lap_ff <= ed3_pkg::abs_clamp(lp);
      end
   end

   // Square root, two radicand bits retired per step.
   localparam int QW = ed3_pkg::ROOT_W;
   logic [QW-1:0] num_ff, res_ff, bit_ff;
   logic [ed3_pkg::STEP_W-1:0] step_ff;
   logic [QW-1:0] trial;
   logic [15:0] gx_sq, gy_sq;

   assign gx_sq = gx_ff * gx_ff;
   assign gy_sq = gy_ff * gy_ff;
   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         num_ff  <= QW'(gx_sq) + QW'(gy_sq);
         res_ff  <= '0;
         bit_ff  <= QW'(1) << (2 * (ed3_pkg::ROOT_STEPS - 1));
         step_ff <= '0;
      end else if (cmd.root_step) begin
         if (num_ff >= trial) begin
            num_ff <= num_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff  <= bit_ff >> 2;
         step_ff <= step_ff + ed3_pkg::STEP_W'(1);
      end
   end

   assign status.root_last = (step_ff == ed3_pkg::STEP_W'(ed3_pkg::ROOT_STEPS - 1));

   // Result register.
   logic [PW-1:0] mag;
   logic          out_v_ff;
   logic [PW-1:0] out_val_ff;
   logic          out_end_ff;

   always_comb begin
      if (!inner_ff) begin
         mag = '0;
      end else if (mode_ff[1]) begin
         mag = lap_ff;
      end else if (res_ff > QW'(255)) begin
         mag = 8'hFF;
      end else begin
         mag = res_ff[PW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (cmd.load_out && has_ff) begin
         out_v_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out && has_ff) begin
         out_val_ff <= mag;
         out_end_ff <= last_ff;
      end
   end

   assign status.out_busy = out_v_ff && !rsp_ready;
   assign rsp_valid       = out_v_ff;
   assign rsp_edge_value  = out_val_ff;
   assign rsp_frame_end   = out_end_ff;

endmodule

FILE: rtl/core/edge_detect_3x3.sv
// Top level of the streaming 3x3 edge detector.
// This block takes 8-bit grey pixels in raster order and returns an edge strength
// word for the pixel that lies frame_width+1 positions behind the newest input
// word, using Prewitt or Sobel gradient magnitude or a four-neighbor Laplacian.
// After each frame the source sends frame_width+1 padding words to flush the last
// rows; the result for the frame's final pixel carries frame_end. The first
// frame_width+1 words of a frame produce no result, and border pixels give zero.
// One word is processed at a time. After the accepting edge the sequencer steps
// through the registered line store read, the window shift, the kernel sums, the
// squares and the square root unit, which retires two bits of the radicand and
// yields one root bit per cycle, and then loads the result register. A new word
// is accepted only after the block returns to idle. A finished result sits in
// an output register, so a stalled result channel only holds the block when the
// next result is ready.
// The line stores need no clearing after reset; configuration must be written
// only while the block is idle, which the block itself does not enforce.
module edge_detect_3x3 #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [12:0]   csr_wdata,
   ed3_req_if.sink       req_chan,
   ed3_rsp_if.source     rsp_chan
);

   ed3_pkg::cmd_type    cmd;
   ed3_pkg::status_type status;

   // The sequencer owns the input handshake; the datapath owns the result register.
   ed3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ed3_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .in_pixel       (req_chan.pixel),
      .in_is_padding  (req_chan.is_padding),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_edge_value (rsp_chan.edge_value),
      .rsp_frame_end  (rsp_chan.frame_end),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

FILE: rtl/core/ed3_checker.sv
// Port level checks of the edge detector, bound to its top level.
module ed3_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_edge_value,
   input logic       rsp_frame_end
);

   // A result word stays offered until taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // A stalled result word keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_edge_value) && $stable(rsp_frame_end))
      else $error("result word changed while stalled");

   // Only one word is in work at a time, so acceptance closes the input.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input open right after an accepted word");

   // A result is loaded only while the input is closed for a word in work.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared with the block idle");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind edge_detect_3x3 ed3_checker u_ed3_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_edge_value (rsp_chan.edge_value),
   .rsp_frame_end  (rsp_chan.frame_end)
);

FILE: tb/testbench.sv
// Self-checking testbench of the streaming 3x3 edge detector.
`timescale 1ns / 100ps

module testbench;

   localparam int LINE_DEPTH = 4096;
   localparam int DRAIN_WAIT = 20;    // beyond the time a word spends inside the block
   localparam int STALL_LIMIT = 2000; // cycles without any handshake
   localparam int ITEM_GOAL = 1500;

   typedef struct {
      logic [7:0] edge_value;
      logic       frame_end;
   } edge_word_type;

   // Scoreboard: a bit-true copy of the detector plus the queue of results
   // it has predicted but not yet seen.
   class edge_scoreboard;
      logic [1:0]  mode;
      logic [12:0] width_reg;
      logic [12:0] height_reg;
      logic [7:0]  line_a [LINE_DEPTH];
      logic [7:0]  line_b [LINE_DEPTH];
      logic [7:0]  win [9];
      int unsigned col;
      int unsigned row;
      edge_word_type pending [$];
      int          errors;
      int          results;
      bit          frame_closed;

      function new();
         mode = ed3_pkg::MODE_SOBEL;
         width_reg = 13'd512;
         height_reg = 13'd512;
         foreach (win[i]) win[i] = '0;
         foreach (line_a[i]) begin
            line_a[i] = '0;
            line_b[i] = '0;
         end
         col = 0;
         row = 0;
         errors = 0;
         results = 0;
      endfunction

      function void set_reg(logic [1:0] index, logic [12:0] value);
         case (index)
            ed3_pkg::CSR_KERNEL_MODE: mode = value[1:0];
            ed3_pkg::CSR_FRAME_WIDTH: width_reg = value;
            ed3_pkg::CSR_FRAME_HEIGHT: height_reg = value;
            default: ;
         endcase
      endfunction

      function int unsigned eff_width();
         if (width_reg < 3) return 3;
         if (width_reg > LINE_DEPTH) return LINE_DEPTH;
         return width_reg;
      endfunction

      function int unsigned eff_height();
         if (height_reg < 3) return 3;
         if (height_reg > ed3_pkg::MAX_HEIGHT) return ed3_pkg::MAX_HEIGHT;
         return height_reg;
      endfunction

      // True while the next word still belongs to the image rather than the flush.
      function bit in_pixels();
         int unsigned r;
         r = row;
         if (col >= eff_width()) r = r + 1;
         return r < eff_height();
      endfunction

      function int unsigned abs_clip(int s);
         if (s < 0) s = -s;
         return (s > 255) ? 255 : s;
      endfunction

      function int unsigned magnitude();
         int w [9];
         int unsigned gx, gy, n, m;
         foreach (w[i]) w[i] = win[i];
         if (mode[1]) return abs_clip(w[1] + w[3] + w[5] + w[7] - 4 * w[4]);
         if (mode == ed3_pkg::MODE_PREWITT) begin
            gx = abs_clip(w[2] + w[5] + w[8] - w[0] - w[3] - w[6]);
            gy = abs_clip(w[6] + w[7] + w[8] - w[0] - w[1] - w[2]);
         end else begin
            gx = abs_clip(w[2] + 2 * w[5] + w[8] - w[0] - 2 * w[3] - w[6]);
            gy = abs_clip(w[6] + 2 * w[7] + w[8] - w[0] - 2 * w[1] - w[2]);
         end
         n = gx * gx + gy * gy;
         m = 0;
         while ((m + 1) * (m + 1) <= n) m++;
         return (m > 255) ? 255 : m;
      endfunction

      // Advances the copy by one accepted input word and queues its result, if it has one.
      function void note_word(logic [7:0] pixel, logic is_padding);
         int unsigned ew, eh, c, r, pr, pc, val;
         logic [7:0] v;
         bit has, last;
         edge_word_type e;
         ew = eff_width();
         eh = eff_height();
         v = is_padding ? 8'd0 : pixel;
         val = 0;
         if (col >= ew) begin
            col = 0;
            row++;
         end
         c = col;
         r = row;
         for (int i = 0; i < 3; i++) begin
            win[i * 3] = win[i * 3 + 1];
            win[i * 3 + 1] = win[i * 3 + 2];
         end
         win[2] = line_b[c];
         win[5] = line_a[c];
         win[8] = v;
         line_b[c] = line_a[c];
         line_a[c] = v;
         has = !(r == 0 || (r == 1 && c == 0));
         last = (r >= eh + 1);
         if (has) begin
            if (c >= 1) begin
               pr = r - 1;
               pc = c - 1;
            end else begin
               pr = r - 2;
               pc = ew - 1;
            end
            if (pr >= 1 && pr <= eh - 2 && pc >= 1 && pc <= ew - 2) val = magnitude();
         end
         if (last) begin
            col = 0;
            row = 0;
            frame_closed = 1;
         end else begin
            col = c + 1;
            if (col >= ew) begin
               col = 0;
               row = r + 1;
            end
         end
         if (has) begin
            e.edge_value = val[7:0];
            e.frame_end = last;
            pending.push_back(e);
         end
      endfunction

      function void check_word(logic [7:0] edge_value, logic frame_end);
         edge_word_type e;
         results++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result edge_value=%0d frame_end=%0b",
                     $time, edge_value, frame_end);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (edge_value !== e.edge_value) begin
            $display("%0t: edge_value expected %0d actual %0d",
                     $time, e.edge_value, edge_value);
            errors++;
         end
         if (frame_end !== e.frame_end) begin
            $display("%0t: frame_end expected %0b actual %0b",
                     $time, e.frame_end, frame_end);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [12:0] csr_wdata = '0;

   ed3_req_if req_bus();
   ed3_rsp_if rsp_bus();

   edge_scoreboard board = new();
   int  words_sent = 0;
   int  frames_done = 0;
   int  idle_cycles = 0;
   bit  calm = 0;     // when set, both sides run without gaps
   bit  shrunk = 0;

   edge_detect_3x3 dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   always #5 clock = ~clock;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.pixel = '0;
      req_bus.is_padding = 1'b0;
      rsp_bus.ready = 1'b0;
   end

   // The watchdog ends a run that stops moving words on either channel.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d quiet cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(0, 10);
   endfunction

   // Result side: stalls a random number of cycles before each word.
   initial begin
      int gap;
      @(negedge reset);
      @(posedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         board.check_word(rsp_bus.edge_value, rsp_bus.frame_end);
      end
   end

   // Sends one word after a random gap; valid stays high when the gap is zero.
   task automatic send_word(logic [7:0] pixel, logic is_padding);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pixel <= pixel;
      req_bus.is_padding <= is_padding;
      do @(posedge clock); while (!req_bus.ready);
      board.note_word(pixel, is_padding);
      words_sent++;
   endtask

   // Waits until every predicted result has come, then lets the pipeline settle.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Raises the write enable, then drops it and waits with it low, so back-to-back writes never
   // drive the enable twice in one step.
   task automatic write_reg(logic [1:0] index, logic [12:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_reg(index, value);
      @(posedge clock);
   endtask

   // Streams one frame until its last word has been accepted. Padding flags are
   // flipped now and then so that zero pixels appear inside the image and real
   // pixels inside the flush. A pause or a width shrink may fall mid-frame.
   task automatic run_frame(int noise_pct, bit mid_pause, bit shrink);
      int count, split;
      logic [7:0] pix;
      logic pad;
      bit flip;
      count = 0;
      split = $urandom_range(4, 20);
      board.frame_closed = 0;
      while (!board.frame_closed) begin
         case ($urandom_range(0, 3))
            0: pix = 8'd0;
            1: pix = 8'd255;
            default: pix = $urandom;
         endcase
         flip = ($urandom_range(0, 99) < noise_pct);
         pad = board.in_pixels() ? flip : !flip;
         send_word(pix, pad);
         count++;
         if (count == split && !board.frame_closed) begin
            if (mid_pause) drain();
            if (shrink) begin
               drain();
               write_reg(ed3_pkg::CSR_FRAME_WIDTH, 13'(board.eff_width() - 1));
            end
         end
      end
      frames_done++;
   endtask

   task automatic configure(int mode, int width, int height);
      drain();
      write_reg(ed3_pkg::CSR_KERNEL_MODE, 13'(mode));
      write_reg(ed3_pkg::CSR_FRAME_WIDTH, 13'(width));
      write_reg(ed3_pkg::CSR_FRAME_HEIGHT, 13'(height));
   endtask

   initial begin
      int w, h;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: smallest frame, Prewitt, with pixels drawn from 0, 255 and random values.
      configure(0, 3, 3);
      run_frame(20, 0, 0);

      // Random frames of small size; some runs are calm, some pause mid-frame,
      // and at most one shrinks the width while the frame is open.
      while (words_sent < ITEM_GOAL) begin
         w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
         h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
         calm = ($urandom_range(0, 4) == 0);
         configure($urandom_range(0, 3), w, h);
         if (!shrunk && w >= 6 && h >= 4) begin
            shrunk = 1;
            run_frame(5, 0, 1);
         end else begin
            run_frame($urandom_range(0, 15), $urandom_range(0, 7) == 0, 0);
         end
      end

      drain();
      if (board.pending.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, board.pending.size());
         board.errors++;
      end
      $display("Sent %0d words in %0d frames, checked %0d results in all kernel modes,",
               words_sent, frames_done, board.results);
      $display("including undersized frame sizes, a mid-frame width shrink and flag noise.");
      if (board.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
